// ----- hw/rtl/mono_frame_delta_run_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// mono_frame_delta_run_encoder assertion macros
// Shared property forms; every user has i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAME_DELTA_RUN_ENCODER_DEFINES_SVH
`define MONO_FRAME_DELTA_RUN_ENCODER_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define MFDRE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive during reset.
`define MFDRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mfdre_pkg.sv -----
// ----------------------------------------------------------------------------
// mfdre_pkg
// Shared constants and the front-to-back queue beat type.
// ----------------------------------------------------------------------------
package mfdre_pkg;

    localparam int HALF_WIDTH_DEF = 64;
    localparam int PAGE_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;

    // widths sized for the largest supported geometry
    localparam int COL_MAX_W  = 7;
    localparam int PAGE_MAX_W = 4;

    // result field widths
    localparam int DATA_W      = 8;
    localparam int RUN_LEN_W   = 7;
    localparam int START_COL_W = 6;
    localparam int PAGE_IDX_W  = 3;

    // one classified frame byte
    typedef struct packed {
        logic                  changed;
        logic [DATA_W-1:0]     data;
        logic [COL_MAX_W-1:0]  local_col;
        logic                  chip;
        logic [PAGE_MAX_W-1:0] page;
        logic                  half_end;
    } t_qbeat;

endpackage

// ----- hw/rtl/mono_frame_delta_run_encoder.sv -----
// ----------------------------------------------------------------------------
// mono_frame_delta_run_encoder
// Frame delta run encoder for a two-half, page-packed monochrome display.
// ----------------------------------------------------------------------------
// Feed frame bytes in scan order (page, then left/right half, then column).
// Each byte is compared with the same place of the previous frame, which is
// all zero after reset, and written back. Consecutive changed bytes inside a
// half form a run; the run closes at the first unchanged byte or at the last
// column of the half, and is then sent as one beat per data byte. Every beat
// repeats the run header (chip, length, start column, page) and flags the
// first and last byte. After reset the previous-frame store is cleared, all
// 2*HALF_WIDTH*PAGE_COUNT entries (1024 by default), with the input stalled.
// The front takes a byte and reads its previous-frame entry in its accept
// state, then compares, writes back and queues it in its write state, which
// waits while the queue is full; no new byte is taken before that. A closed
// run drains one result beat at a time (run buffer read, then output
// register, held while the receiver stalls). Input bytes keep flowing into
// a 4-beat queue while a run drains; the write state, and so the input
// stall, is held longer only when that queue is full.
// ----------------------------------------------------------------------------
module mono_frame_delta_run_encoder
    import mfdre_pkg::*;
#(
    parameter int HALF_WIDTH = HALF_WIDTH_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [DATA_W-1:0]      i_pixel_byte,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_run_first,
    output logic                   o_chip_select,
    output logic [RUN_LEN_W-1:0]   o_run_length,
    output logic [START_COL_W-1:0] o_start_column,
    output logic [PAGE_IDX_W-1:0]  o_page_index,
    output logic [DATA_W-1:0]      o_data_byte,
    output logic                   o_run_last
);

    t_qbeat q_in_beat;
    t_qbeat q_out_beat;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    // front: scan counters, previous-frame compare and write-back
    mfdre_front #(
        .HALF_WIDTH (HALF_WIDTH),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_byte (i_pixel_byte),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_beat     (q_in_beat)
    );

    // decouples byte intake from run draining
    mfdre_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_beat  (q_in_beat),
        .i_pop   (q_pop),
        .o_beat  (q_out_beat),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: run assembly and result beats
    mfdre_back #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_beat       (q_out_beat),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_run_first    (o_run_first),
        .o_chip_select  (o_chip_select),
        .o_run_length   (o_run_length),
        .o_start_column (o_start_column),
        .o_page_index   (o_page_index),
        .o_data_byte    (o_data_byte),
        .o_run_last     (o_run_last)
    );

endmodule

// ----- hw/rtl/mfdre_front.sv -----
// ----------------------------------------------------------------------------
// mfdre_front
// Accepts frame bytes, compares against the previous-frame store, classifies.
// ----------------------------------------------------------------------------
module mfdre_front
    import mfdre_pkg::*;
#(
    parameter int HALF_WIDTH = HALF_WIDTH_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_pixel_byte,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_qbeat            o_q_beat
);

    localparam int FRAME_BYTES = 2 * HALF_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int LOCAL_W     = $clog2(HALF_WIDTH);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    typedef enum logic [2:0] {
        F_CLEAR  = 3'b001,
        F_ACCEPT = 3'b010,
        F_WRITE  = 3'b100
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [LOCAL_W-1:0]  r_local, n_local;
    logic                r_chip, n_chip;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [DATA_W-1:0]   r_byte;
    logic [DATA_W-1:0]   r_prev;
    logic [DATA_W-1:0]   r_mem [FRAME_BYTES];

    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                half_end;

    assign half_end   = (r_local == LOCAL_W'(HALF_WIDTH - 1));
    assign o_in_stall = (r_state != F_ACCEPT);
    assign mem_re     = (r_state == F_ACCEPT) && i_in_valid;
    assign o_q_push   = (r_state == F_WRITE) && !i_q_full;
    assign mem_we     = (r_state == F_CLEAR) || o_q_push;
    assign mem_waddr  = (r_state == F_CLEAR) ? r_clr_addr : r_addr;
    assign mem_wdata  = (r_state == F_CLEAR) ? '0 : r_byte;

    always_comb begin
        o_q_beat.changed   = (r_prev != r_byte);
        o_q_beat.data      = r_byte;
        o_q_beat.local_col = COL_MAX_W'(r_local);
        o_q_beat.chip      = r_chip;
        o_q_beat.page      = PAGE_MAX_W'(r_page);
        o_q_beat.half_end  = half_end;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_addr     = r_addr;
        n_local    = r_local;
        n_chip     = r_chip;
        n_page     = r_page;
        case (r_state)
            F_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(FRAME_BYTES - 1)) begin
                    n_state = F_ACCEPT;
                end
            end
            F_ACCEPT: begin
                if (i_in_valid) begin
                    n_state = F_WRITE;
                end
            end
            F_WRITE: begin
                if (!i_q_full) begin
                    n_state = F_ACCEPT;
                    n_addr  = (r_addr == ADDR_W'(FRAME_BYTES - 1)) ? '0 : r_addr + ADDR_W'(1);
                    if (half_end) begin
                        n_local = '0;
                        n_chip  = !r_chip;
                        if (r_chip) begin
                            n_page = (r_page == PAGE_W'(PAGE_COUNT - 1)) ? '0
                                                                         : r_page + PAGE_W'(1);
                        end
                    end else begin
                        n_local = r_local + LOCAL_W'(1);
                    end
                end
            end
            default: begin
                n_state = F_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_CLEAR;
            r_clr_addr <= '0;
            r_addr     <= '0;
            r_local    <= '0;
            r_chip     <= 1'b0;
            r_page     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_addr     <= n_addr;
            r_local    <= n_local;
            r_chip     <= n_chip;
            r_page     <= n_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_byte <= i_pixel_byte;
        end
    end

    // previous-frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_prev <= r_mem[r_addr];
        end
    end

endmodule

// ----- hw/rtl/mfdre_fifo.sv -----
// ----------------------------------------------------------------------------
// mfdre_fifo
// Short queue of classified beats between front and back.
// ----------------------------------------------------------------------------
`include "mono_frame_delta_run_encoder_defines.svh"

module mfdre_fifo
    import mfdre_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qbeat i_beat,
    input  logic   i_pop,
    output t_qbeat o_beat,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qbeat           r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_beat  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_beat;
        end
    end

    `MFDRE_ASSERT_IMPL(a_no_overflow, i_push, !o_full, "queue push while full")
    `MFDRE_ASSERT_IMPL(a_no_underflow, i_pop, !o_empty, "queue pop while empty")

endmodule

// ----- hw/rtl/mfdre_back.sv -----
// ----------------------------------------------------------------------------
// mfdre_back
// Builds runs from classified beats and drains closed runs byte by byte.
// ----------------------------------------------------------------------------
`include "mono_frame_delta_run_encoder_defines.svh"

module mfdre_back
    import mfdre_pkg::*;
#(
    parameter int HALF_WIDTH = HALF_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_qbeat                 i_q_beat,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_run_first,
    output logic                   o_chip_select,
    output logic [RUN_LEN_W-1:0]   o_run_length,
    output logic [START_COL_W-1:0] o_start_column,
    output logic [PAGE_IDX_W-1:0]  o_page_index,
    output logic [DATA_W-1:0]      o_data_byte,
    output logic                   o_run_last
);

    localparam int LOCAL_W = $clog2(HALF_WIDTH);
    localparam int CNT_W   = $clog2(HALF_WIDTH + 1);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SEND = 3'b100
    } t_bstate;

    t_bstate               r_state, n_state;
    logic                  r_open, n_open;
    logic [LOCAL_W-1:0]    r_begin, n_begin;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_len, n_len;
    logic                  r_chip, n_chip;
    logic [PAGE_MAX_W-1:0] r_page, n_page;
    logic [LOCAL_W-1:0]    r_k, n_k;
    logic [DATA_W-1:0]     r_rd_data;
    logic [DATA_W-1:0]     r_store [HALF_WIDTH];

    logic                  r_out_valid;
    logic                  r_out_first;
    logic                  r_out_chip;
    logic [RUN_LEN_W-1:0]  r_out_len;
    logic [START_COL_W-1:0] r_out_col;
    logic [PAGE_IDX_W-1:0] r_out_page;
    logic [DATA_W-1:0]     r_out_data;
    logic                  r_out_last;

    logic                  st_we;
    logic [LOCAL_W-1:0]    st_waddr;
    logic [CNT_W-1:0]      cnt_base;
    logic [CNT_W-1:0]      cnt_new;
    logic                  run_live;
    logic                  out_load;
    logic                  send_last;

    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign run_live  = r_open || i_q_beat.changed;
    assign out_load  = (r_state == B_SEND) && (!r_out_valid || !i_out_stall);
    assign send_last = ((CNT_W'(r_k) + CNT_W'(1)) == r_len);

    always_comb begin
        n_state  = r_state;
        n_open   = r_open;
        n_begin  = r_begin;
        n_count  = r_count;
        n_len    = r_len;
        n_chip   = r_chip;
        n_page   = r_page;
        n_k      = r_k;
        st_we    = 1'b0;
        cnt_base = r_open ? r_count : '0;
        cnt_new  = cnt_base + CNT_W'(1);
        st_waddr = cnt_base[LOCAL_W-1:0];
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_beat.changed) begin
                        st_we   = 1'b1;
                        n_open  = 1'b1;
                        n_count = cnt_new;
                        if (!r_open) begin
                            n_begin = i_q_beat.local_col[LOCAL_W-1:0];
                        end
                    end
                    // close on an unchanged byte or at the last column of a half
                    if (run_live && (!i_q_beat.changed || i_q_beat.half_end)) begin
                        n_len   = i_q_beat.changed ? cnt_new : r_count;
                        n_chip  = i_q_beat.chip;
                        n_page  = i_q_beat.page;
                        n_open  = 1'b0;
                        n_count = '0;
                        n_k     = '0;
                        n_state = B_READ;
                    end
                end
            end
            B_READ: begin
                n_state = B_SEND;
            end
            B_SEND: begin
                if (out_load) begin
                    n_k     = r_k + LOCAL_W'(1);
                    n_state = send_last ? B_IDLE : B_READ;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_open      <= 1'b0;
            r_begin     <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_begin     <= n_begin;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_chip <= n_chip;
        r_page <= n_page;
        if (out_load) begin
            r_out_first <= (r_k == '0);
            r_out_chip  <= r_chip;
            r_out_len   <= RUN_LEN_W'(r_len);
            r_out_col   <= START_COL_W'(r_begin);
            r_out_page  <= PAGE_IDX_W'(r_page);
            r_out_data  <= r_rd_data;
            r_out_last  <= send_last;
        end
    end

    // run buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= i_q_beat.data;
        end
        if (r_state == B_READ) begin
            r_rd_data <= r_store[r_k];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_run_first    = r_out_first;
    assign o_chip_select  = r_out_chip;
    assign o_run_length   = r_out_len;
    assign o_start_column = r_out_col;
    assign o_page_index   = r_out_page;
    assign o_data_byte    = r_out_data;
    assign o_run_last     = r_out_last;

    `MFDRE_ASSERT_IMPL(a_drain_closed, r_state != B_IDLE, !r_open, "run open during drain")
    `MFDRE_ASSERT_IMPL(a_len_nonzero, r_state == B_READ, r_len != '0, "empty run drained")
    `MFDRE_ASSERT_NEXT(a_last_idle, out_load && send_last, r_state == B_IDLE, "no idle after last")

endmodule

// ----- verif/mono_frame_delta_run_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_frame_delta_run_encoder_tb
// Streams frame bytes into the delta run encoder and scores every run beat
// against a cycle-free frame/run predictor kept inside this bench.
// ----------------------------------------------------------------------------
module mono_frame_delta_run_encoder_tb;
    import mfdre_pkg::*;

    localparam int HALF      = HALF_WIDTH_DEF;
    localparam int PAGES     = PAGE_COUNT_DEF;
    localparam int ROW       = 2 * HALF;
    localparam int FRAME     = ROW * PAGES;
    // A few pages of traffic against the cleared store.
    localparam int TOTAL_ITEMS = 350;
    localparam int IDLE_PCT    = 35;
    localparam int HOLD_START  = 1250;  // receiver hold-off begins here
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LO    = 1750;  // no idling on either side in here
    localparam int QUIET_HI    = 2050;
    localparam int TAIL_CYCLES = 64;
    // covers the clear pass, the hold-off and random stalls, with wide margin
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                   first;
        logic                   chip;
        logic [RUN_LEN_W-1:0]   len;
        logic [START_COL_W-1:0] col;
        logic [PAGE_IDX_W-1:0]  page;
        logic [DATA_W-1:0]      data;
        logic                   last;
    } t_run_beat;

    function automatic string beat_str(input t_run_beat bt);
        return $sformatf("first=%0d chip=%0d len=%0d col=%0d page=%0d data=%02h last=%0d",
                         bt.first, bt.chip, bt.len, bt.col, bt.page, bt.data, bt.last);
    endfunction

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic [DATA_W-1:0]      i_pixel_byte   = '0;
    logic                   i_out_stall    = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_run_first;
    logic                   o_chip_select;
    logic [RUN_LEN_W-1:0]   o_run_length;
    logic [START_COL_W-1:0] o_start_column;
    logic [PAGE_IDX_W-1:0]  o_page_index;
    logic [DATA_W-1:0]      o_data_byte;
    logic                   o_run_last;

    mono_frame_delta_run_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_byte   (i_pixel_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_run_first    (o_run_first),
        .o_chip_select  (o_chip_select),
        .o_run_length   (o_run_length),
        .o_start_column (o_start_column),
        .o_page_index   (o_page_index),
        .o_data_byte    (o_data_byte),
        .o_run_last     (o_run_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // free-running cycle count, read by the idling processes
    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus store: bytes waiting for the driver, plus a shadow of the
    // frame as sent so the generator can pick changed/unchanged bytes.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] pixel_queue [$];
    logic [DATA_W-1:0] sent_frame [FRAME];
    int                gen_pos = 0;

    task automatic queue_byte(input logic [DATA_W-1:0] b);
        pixel_queue.push_back(b);
        sent_frame[gen_pos] = b;
        gen_pos = (gen_pos + 1) % FRAME;
    endtask

    function automatic logic [DATA_W-1:0] differ_from(input logic [DATA_W-1:0] old);
        return old ^ 8'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------
    // Predictor: previous frame, scan position and the open run.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] prev_frame [FRAME];
    logic [DATA_W-1:0] run_bytes [HALF];
    int                scan_col;
    int                scan_page;
    int                run_start;
    int                run_len;
    bit                run_active;
    t_run_beat         beat_queue [$];

    int bytes_taken  = 0;
    int runs_closed  = 0;
    int full_runs    = 0;
    int half_closes  = 0;
    int frame_wraps  = 0;
    int beats_seen   = 0;
    int mismatches   = 0;
    int fill_stalls  = 0;

    // One frame byte in scan order; queues every beat of a run it closes.
    task automatic encode_byte(input logic [DATA_W-1:0] b);
        int        idx;
        int        local_col;
        bit        chip;
        bit        changed;
        t_run_beat beat;
        chip      = (scan_col >= HALF);
        local_col = chip ? scan_col - HALF : scan_col;
        idx       = scan_page * ROW + scan_col;
        changed   = (prev_frame[idx] != b);
        prev_frame[idx] = b;

        if (changed) begin
            if (!run_active) begin
                run_active = 1'b1;
                run_start  = local_col;
                run_len    = 0;
            end
            run_bytes[run_len] = b;
            run_len++;
        end

        // close on an unchanged byte, or at the last column of the half
        if (run_active && (!changed || local_col == HALF - 1)) begin
            for (int k = 0; k < run_len; k++) begin
                beat.first = (k == 0);
                beat.chip  = chip;
                beat.len   = RUN_LEN_W'(run_len);
                beat.col   = START_COL_W'(run_start);
                beat.page  = PAGE_IDX_W'(scan_page);
                beat.data  = run_bytes[k];
                beat.last  = (k == run_len - 1);
                beat_queue.push_back(beat);
            end
            runs_closed++;
            if (run_len == HALF) full_runs++;
            if (changed) half_closes++;
            run_active = 1'b0;
            run_len    = 0;
        end

        scan_col++;
        if (scan_col == ROW) begin
            scan_col = 0;
            scan_page++;
            if (scan_page == PAGES) begin
                scan_page = 0;
                frame_wraps++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: holds a beat until taken, then maybe idles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_pixel_byte <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pixel_queue.size() != 0 &&
                ((cyc >= QUIET_LO && cyc < QUIET_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid   <= 1'b1;
                i_pixel_byte <= pixel_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, one long hold-off so the input queue fills
    // and the encoder has to stall its input side.
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && cyc >= HOLD_START) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
        end else if (cyc >= QUIET_LO && cyc < QUIET_HI) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on accepted input beats, scores accepted result
    // beats in order, and runs the no-progress watchdog.
    // ------------------------------------------------------------------
    int idle_count = 0;
    always @(posedge i_clk) begin
        t_run_beat got;
        t_run_beat want;
        if (!i_rst_n) begin
            foreach (prev_frame[i]) prev_frame[i] = '0;
            scan_col   = 0;
            scan_page  = 0;
            run_start  = 0;
            run_len    = 0;
            run_active = 1'b0;
            idle_count = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                encode_byte(i_pixel_byte);
                bytes_taken++;
            end
            if (i_in_valid && o_in_stall && hold_left > 0) fill_stalls++;

            if (o_out_valid && !i_out_stall) begin
                got = {o_run_first, o_chip_select, o_run_length, o_start_column,
                       o_page_index, o_data_byte, o_run_last};
                beats_seen++;
                if (beat_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] result beat with nothing pending: data=%02h len=%0d",
                                 $realtime, got.data, got.len);
                end else begin
                    want = beat_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] beat %0d mismatch", $realtime, beats_seen);
                            $display("  exp %s", beat_str(want));
                            $display("  got %s", beat_str(got));
                        end
                    end
                end
            end

            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset, and end of run
    // ------------------------------------------------------------------
    initial begin : main
        logic [DATA_W-1:0] b;
        int                seg_left;
        bit                seg_changed;
        int                n_items;
        seg_left    = 0;
        seg_changed = 1'b0;
        foreach (sent_frame[i]) sent_frame[i] = '0;

        // Directed opening, page 0 left half against the cleared frame.
        queue_byte(8'hFF);                      // lone changed byte
        queue_byte(8'h00);                      // unchanged byte closes it
        for (int i = 0; i < 8; i++) queue_byte(8'h01 << i);      // walking one
        queue_byte(8'h00);
        for (int i = 0; i < 8; i++) queue_byte(~(8'h01 << i));   // walking zero
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'h55);
        queue_byte(8'hAA);
        queue_byte(8'h00);

        // Random part: segments of changed / unchanged bytes, now and then a
        // whole half changed so a run reaches the half boundary at full size,
        // with a sprinkle of fully random bytes as noise.
        while (pixel_queue.size() < TOTAL_ITEMS) begin
            if (seg_left == 0) begin
                if (gen_pos % HALF == 0 && $urandom_range(0, 7) == 0) begin
                    seg_changed = 1'b1;
                    seg_left    = HALF;
                end else begin
                    seg_changed = 1'($urandom_range(0, 1));
                    seg_left    = $urandom_range(1, 10);
                end
            end
            if ($urandom_range(0, 19) == 0)
                b = 8'($urandom);
            else if (seg_changed)
                b = differ_from(sent_frame[gen_pos]);
            else
                b = sent_frame[gen_pos];
            queue_byte(b);
            seg_left--;
        end
        queue_byte(sent_frame[gen_pos]);        // trailing unchanged byte
        n_items = pixel_queue.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (bytes_taken < n_items);
        while (beat_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d frame bytes over %0d frame wrap(s); %0d runs, %0d full-half",
                 bytes_taken, frame_wraps, runs_closed, full_runs);
        $display("%0d half-end closes, %0d result beats, %0d input stalls in hold-off",
                 half_closes, beats_seen, fill_stalls);
        if (mismatches == 0 && beat_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d beats still pending", mismatches, beat_queue.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mfdre_pkg.sv
hw/rtl/mfdre_front.sv
hw/rtl/mfdre_fifo.sv
hw/rtl/mfdre_back.sv
hw/rtl/mono_frame_delta_run_encoder.sv
verif/mono_frame_delta_run_encoder_tb.sv
